@@ hw/rtl/lebc_pkg.sv @@
`timescale 1ns / 1ps
// lebc_pkg: types, constants and opcode classification for the leb128 canonicalizer
// depends on nothing; imported by opcode_stream_leb128_canonicalizer_unit
package lebc_pkg;

	localparam int VALUE_BITS   = 64;
	localparam int DIGIT_BITS   = 7;
	// digits needed to cover VALUE_BITS, the last one may be partial
	localparam int LEB_DIGITS   = (VALUE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int LAST_BITS    = VALUE_BITS - (LEB_DIGITS - 1) * DIGIT_BITS;
	localparam int CNT_W        = $clog2(LEB_DIGITS + 1);
	localparam int FIX_W        = 4;
	localparam int VALS_W       = 2;

	localparam logic [FIX_W-1:0] FIX_LONG   = FIX_W'(8);
	localparam logic [FIX_W-1:0] FIX_SHORT  = FIX_W'(4);
	localparam logic [FIX_W-1:0] TARGET_LEN = FIX_W'(4);

	localparam logic [7:0] OP_BR_TABLE = 8'h08;
	localparam logic [7:0] OP_CONST64  = 8'h12;
	localparam logic [7:0] OP_CONST32  = 8'h13;

	typedef enum logic [2:0] {
		MODE_OPCODE,
		MODE_FIXED,
		MODE_ULEB,
		MODE_SLEB,
		MODE_BR_FIRST,
		MODE_BR_COUNT,
		MODE_TARGETS
	} parse_mode_t;

	typedef enum logic {
		ST_RUN,
		ST_EMIT
	} ctl_state_t;

	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_SLEB,
		CLS_ULEB1,
		CLS_ULEB2,
		CLS_FIX8,
		CLS_FIX4,
		CLS_BRTAB,
		CLS_BAD
	} op_class_t;

	function automatic op_class_t op_class(input logic [7:0] op);
		op_class_t cls;
		if (op inside {[8'h00:8'h05], 8'h0a, 8'h0f, 8'h39, 8'h3b, [8'h40:8'hba]}) begin
			cls = CLS_NONE;
		end else if (op inside {8'h10, 8'h11}) begin
			cls = CLS_SLEB;
		end else if (op inside {8'h09, 8'h14, 8'h15}) begin
			cls = CLS_ULEB1;
		end else if (op inside {8'h06, 8'h07, [8'h16:8'h18], [8'h20:8'h36]}) begin
			cls = CLS_ULEB2;
		end else if (op == OP_CONST64) begin
			cls = CLS_FIX8;
		end else if (op == OP_CONST32) begin
			cls = CLS_FIX4;
		end else if (op == OP_BR_TABLE) begin
			cls = CLS_BRTAB;
		end else begin
			cls = CLS_BAD;
		end
		return cls;
	endfunction

endpackage

@@ hw/rtl/opcode_stream_leb128_canonicalizer_unit.sv @@
`timescale 1ns / 1ps
// opcode_stream_leb128_canonicalizer_unit: top level of the leb128 canonicalizer
// depends on lebc_pkg
// an opcode or raw byte is loaded into the output register when it is taken
// throughput: one input word per cycle while results are taken; a final leb128 byte starts
// a serial emitter that sends one 7-bit digit per cycle while results are taken, input held meanwhile
// after an unknown opcode one error word is sent and further words are taken and dropped
// reset (arst_n low) returns to opcode mode, clears the accumulator, counters and halt flag
module opcode_stream_leb128_canonicalizer_unit
	import lebc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       body_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       status
);

	ctl_state_t             st_q, st_d;
	parse_mode_t            mode_q, mode_d;
	logic [FIX_W-1:0]       fixed_q, fixed_d;
	logic [VALS_W-1:0]      vals_q, vals_d;
	logic [VALUE_BITS-1:0]  acc_q, acc_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [VALUE_BITS-1:0]  tl_q, tl_d;
	logic                   halted_q, halted_d;
	logic                   sgn_q, sgn_d;

	logic                   out_valid_q;
	logic [7:0]             out_byte_q;
	logic                   out_last_q;
	logic                   out_status_q;

	logic                   out_free;
	logic                   in_fire;
	logic                   emit_start;
	logic                   emit_more;
	logic                   emit_fire;
	logic                   pass_load;
	logic                   pass_status;
	logic [VALUE_BITS-1:0]  acc_shift;
	logic [VALUE_BITS-DIGIT_BITS-1:0] upper;

	assign out_free = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// serial emitter: low digit of acc_q goes out, the rest shifts down
	assign upper = acc_q[VALUE_BITS-1:DIGIT_BITS];
	always_comb begin
		if (sgn_q) begin
			emit_more = !(((upper == '0) && !acc_q[DIGIT_BITS-1]) ||
				((&upper) && acc_q[DIGIT_BITS-1]));
			acc_shift = {{DIGIT_BITS{acc_q[VALUE_BITS-1]}}, upper};
		end else begin
			emit_more = |upper;
			acc_shift = {{DIGIT_BITS{1'b0}}, upper};
		end
	end

	// next control state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_RUN: begin
				if (emit_start) st_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free && !emit_more) st_d = ST_RUN;
			end
			default: st_d = ST_RUN;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = 1'b0;
		emit_fire = 1'b0;
		case (st_q)
			ST_RUN:  in_ready  = out_free;
			ST_EMIT: emit_fire = out_free;
			default: in_ready  = 1'b0;
		endcase
	end

	// parser step for one accepted word
	always_comb begin
		logic [VALUE_BITS-1:0] v;
		logic [CNT_W-1:0]      cnt_n;
		logic                  fill;
		mode_d      = mode_q;
		fixed_d     = fixed_q;
		vals_d      = vals_q;
		acc_d       = acc_q;
		cnt_d       = cnt_q;
		tl_d        = tl_q;
		halted_d    = halted_q;
		sgn_d       = sgn_q;
		emit_start  = 1'b0;
		pass_load   = 1'b0;
		pass_status = 1'b0;
		v           = acc_q;
		cnt_n       = cnt_q;
		fill        = 1'b0;

		if (emit_fire) begin
			acc_d = emit_more ? acc_shift : '0;
		end

		if (in_fire && !halted_q) begin
			case (mode_q)
				MODE_OPCODE: begin
					pass_load = 1'b1;
					case (op_class(in_byte))
						CLS_NONE: ;
						CLS_SLEB: mode_d = MODE_SLEB;
						CLS_ULEB1: begin
							mode_d = MODE_ULEB;
							vals_d = VALS_W'(1);
						end
						CLS_ULEB2: begin
							mode_d = MODE_ULEB;
							vals_d = VALS_W'(2);
						end
						CLS_FIX8: begin
							mode_d  = MODE_FIXED;
							fixed_d = FIX_LONG;
						end
						CLS_FIX4: begin
							mode_d  = MODE_FIXED;
							fixed_d = FIX_SHORT;
						end
						CLS_BRTAB: mode_d = MODE_BR_FIRST;
						default: begin
							pass_status = 1'b1;
							halted_d    = 1'b1;
						end
					endcase
				end
				MODE_FIXED: begin
					pass_load = 1'b1;
					if (fixed_q != '0) fixed_d = fixed_q - FIX_W'(1);
					if (fixed_d == '0) mode_d = MODE_OPCODE;
				end
				MODE_TARGETS: begin
					pass_load = 1'b1;
					if (fixed_q != '0) fixed_d = fixed_q - FIX_W'(1);
					if (fixed_d == '0) begin
						if (tl_q != '0) tl_d = tl_q - VALUE_BITS'(1);
						if (tl_d != '0) fixed_d = TARGET_LEN;
						else mode_d = MODE_OPCODE;
					end
				end
				default: begin
					// drop the digit into its slot; bits past VALUE_BITS are lost
					for (int i = 0; i < LEB_DIGITS - 1; i++) begin
						if (cnt_q == CNT_W'(i)) v[i*DIGIT_BITS +: DIGIT_BITS] = in_byte[6:0];
					end
					if (cnt_q == CNT_W'(LEB_DIGITS - 1))
						v[VALUE_BITS-1 -: LAST_BITS] = in_byte[LAST_BITS-1:0];
					if (cnt_q < CNT_W'(LEB_DIGITS)) cnt_n = cnt_q + CNT_W'(1);
					acc_d = v;
					cnt_d = cnt_n;
					if (!in_byte[7]) begin
						// sign fill of all digits above the last one received
						fill = (mode_q == MODE_SLEB) && in_byte[6] &&
							(cnt_n < CNT_W'(LEB_DIGITS));
						if (fill) begin
							for (int i = 0; i < LEB_DIGITS - 1; i++) begin
								if (CNT_W'(i) >= cnt_n) v[i*DIGIT_BITS +: DIGIT_BITS] = '1;
							end
							v[VALUE_BITS-1 -: LAST_BITS] = '1;
						end
						acc_d      = v;
						cnt_d      = '0;
						emit_start = 1'b1;
						sgn_d      = (mode_q == MODE_SLEB);
						case (mode_q)
							MODE_SLEB: mode_d = MODE_OPCODE;
							MODE_ULEB: begin
								if (vals_q != '0) vals_d = vals_q - VALS_W'(1);
								if (vals_d == '0) mode_d = MODE_OPCODE;
							end
							MODE_BR_FIRST: mode_d = MODE_BR_COUNT;
							default: begin
								tl_d = v + VALUE_BITS'(1);
								if (tl_d != '0) begin
									fixed_d = TARGET_LEN;
									mode_d  = MODE_TARGETS;
								end else begin
									mode_d = MODE_OPCODE;
								end
							end
						endcase
					end
				end
			endcase

			if (body_end && !halted_d) begin
				mode_d  = MODE_OPCODE;
				fixed_d = '0;
				vals_d  = '0;
				cnt_d   = '0;
				tl_d    = '0;
				// a finished value still has to go out; it is cleared after emission
				if (!emit_start) acc_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_RUN;
			mode_q      <= MODE_OPCODE;
			fixed_q     <= '0;
			vals_q      <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			tl_q        <= '0;
			halted_q    <= 1'b0;
			sgn_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			mode_q   <= mode_d;
			fixed_q  <= fixed_d;
			vals_q   <= vals_d;
			acc_q    <= acc_d;
			cnt_q    <= cnt_d;
			tl_q     <= tl_d;
			halted_q <= halted_d;
			sgn_q    <= sgn_d;
			if (pass_load || emit_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (pass_load) begin
			out_byte_q   <= in_byte;
			out_last_q   <= 1'b1;
			out_status_q <= pass_status;
		end else if (emit_fire) begin
			out_byte_q   <= {emit_more, acc_q[DIGIT_BITS-1:0]};
			out_last_q   <= !emit_more;
			out_status_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;
	assign status      = out_status_q;

`ifndef NO_ASSERTIONS
	// once halted, the only word that can be waiting is the error word
	assert property (@(posedge clk) disable iff (!arst_n)
		halted_q && out_valid_q |-> out_status_q)
		else $error("ok word presented after halt");

	// halt is sticky until reset
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(halted_q) |-> halted_q)
		else $error("halt flag dropped");

	// raw byte modes always have bytes pending
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_TARGETS || mode_q == MODE_FIXED) |-> fixed_q != '0)
		else $error("raw byte mode with no bytes left");
`endif

endmodule
